>>> src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int HUE_W     = 11;
    localparam int CHAN_W    = 8;
    localparam int FRAC_BITS = 8;
    localparam int SECTOR_W  = HUE_W - FRAC_BITS;
    localparam int PROD_W    = CHAN_W + FRAC_BITS;   // S * F and S * (ONE - F)
    localparam int NUM_W     = CHAN_W + PROD_W;      // V * (DEN - S * F)

    localparam logic [FRAC_BITS:0]  ONE   = (FRAC_BITS + 1)'(1 << FRAC_BITS);
    localparam logic [PROD_W-1:0]   DEN   = PROD_W'(255 * (1 << FRAC_BITS));
    localparam logic [CHAN_W-1:0]   FULL  = 8'd255;
    localparam logic [CHAN_W-1:0]   ALPHA_RESET = 8'd255;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    // Fold the raw sector modulo 6; a full turn (and above) wraps back.
    function automatic sector_t sector_fold(input logic [SECTOR_W-1:0] raw);
        logic [SECTOR_W-1:0] folded;
        folded = raw;
        if (raw >= SECTOR_W'(6))
        begin
            folded = raw - SECTOR_W'(6);
        end
        return sector_t'(3'(folded));
    endfunction

    // Exact floor(y / 255) for y up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] y);
        logic [2*CHAN_W:0] sum;
        sum = {1'b0, y} + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(y[2*CHAN_W-1:CHAN_W]);
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

>>> src/hsv2rgb_if.sv
`timescale 1ns / 1ps

interface hsv_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]  hue_fixed;
    logic [hsv2rgb_pkg::CHAN_W-1:0] saturation;
    logic [hsv2rgb_pkg::CHAN_W-1:0] brightness;

    modport source (output valid, hue_fixed, saturation, brightness, input ready);
    modport sink   (input valid, hue_fixed, saturation, brightness, output ready);
endinterface

interface rgba_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [hsv2rgb_pkg::CHAN_W-1:0] red;
    logic [hsv2rgb_pkg::CHAN_W-1:0] green;
    logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
    logic [hsv2rgb_pkg::CHAN_W-1:0] alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

>>> src/hsv_to_rgb_converter.sv
// Throughput: one pixel per cycle while rgba.ready is high; three register
// stages (saturation products, brightness products, divide-by-255 and sector
// mux) each hold one pixel. A stage advances whenever it is empty or the stage
// after it moves on.
// Reset empties all stages and sets the alpha register to 255.
`timescale 1ns / 1ps

module hsv_to_rgb_converter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] cfg_wdata,
    hsv_pixel_if.sink                      hsv,
    rgba_pixel_if.source                   rgba
);

    localparam int CW = hsv2rgb_pkg::CHAN_W;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int NW = hsv2rgb_pkg::NUM_W;
    localparam int FB = hsv2rgb_pkg::FRAC_BITS;
    localparam int SW = hsv2rgb_pkg::SECTOR_W;

    logic [CW-1:0] alpha_level_reg;

    // Stage 1: saturation products
    logic                 s1_valid_reg;
    hsv2rgb_pkg::sector_t s1_sector_reg, s1_sector_next;
    logic [CW-1:0]        s1_v_reg,  s1_v_next;
    logic [PW-1:0]        s1_sf_reg, s1_sf_next;
    logic [PW-1:0]        s1_st_reg, s1_st_next;
    logic [CW-1:0]        s1_ps_reg, s1_ps_next;

    // Stage 2: brightness products
    logic                 s2_valid_reg;
    hsv2rgb_pkg::sector_t s2_sector_reg;
    logic [CW-1:0]        s2_v_reg;
    logic [2*CW-1:0]      s2_pnum_reg, s2_pnum_next;
    logic [NW-1:0]        s2_qnum_reg, s2_qnum_next;
    logic [NW-1:0]        s2_tnum_reg, s2_tnum_next;

    // Stage 3: output register
    logic                 out_valid_reg;
    logic [CW-1:0]        red_reg,   red_next;
    logic [CW-1:0]        green_reg, green_next;
    logic [CW-1:0]        blue_reg,  blue_next;

    logic                 s1_ready, s2_ready, s3_ready;
    logic [FB-1:0]        frac;
    logic [CW-1:0]        p_chan, q_chan, t_chan;

    assign s3_ready  = !out_valid_reg || rgba.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign hsv.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_level_reg <= hsv2rgb_pkg::ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            alpha_level_reg <= cfg_wdata;
        end
    end

    // Stage 1 combinational
    always_comb
    begin
        frac           = hsv.hue_fixed[FB-1:0];
        s1_sector_next = hsv2rgb_pkg::sector_fold(hsv.hue_fixed[FB +: SW]);
        s1_v_next      = hsv.brightness;
        s1_sf_next     = PW'(hsv.saturation) * PW'(frac);
        s1_st_next     = PW'(hsv.saturation) * PW'(hsv2rgb_pkg::ONE - (FB + 1)'(frac));
        s1_ps_next     = hsv2rgb_pkg::FULL - hsv.saturation;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= hsv.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && hsv.valid)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_v_reg      <= s1_v_next;
            s1_sf_reg     <= s1_sf_next;
            s1_st_reg     <= s1_st_next;
            s1_ps_reg     <= s1_ps_next;
        end
    end

    // Stage 2 combinational
    always_comb
    begin
        s2_pnum_next = (2*CW)'(s1_v_reg) * (2*CW)'(s1_ps_reg);
        s2_qnum_next = NW'(s1_v_reg) * NW'(hsv2rgb_pkg::DEN - s1_sf_reg);
        s2_tnum_next = NW'(s1_v_reg) * NW'(hsv2rgb_pkg::DEN - s1_st_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_v_reg      <= s1_v_reg;
            s2_pnum_reg   <= s2_pnum_next;
            s2_qnum_reg   <= s2_qnum_next;
            s2_tnum_reg   <= s2_tnum_next;
        end
    end

    // Stage 3 combinational: drop the fraction bits, divide by 255, pick channels
    always_comb
    begin
        p_chan = hsv2rgb_pkg::div255(s2_pnum_reg);
        q_chan = hsv2rgb_pkg::div255(s2_qnum_reg[NW-1:FB]);
        t_chan = hsv2rgb_pkg::div255(s2_tnum_reg[NW-1:FB]);

        case (s2_sector_reg)
            hsv2rgb_pkg::SECTOR_0:
            begin
                red_next = s2_v_reg; green_next = t_chan;   blue_next = p_chan;
            end
            hsv2rgb_pkg::SECTOR_1:
            begin
                red_next = q_chan;   green_next = s2_v_reg; blue_next = p_chan;
            end
            hsv2rgb_pkg::SECTOR_2:
            begin
                red_next = p_chan;   green_next = s2_v_reg; blue_next = t_chan;
            end
            hsv2rgb_pkg::SECTOR_3:
            begin
                red_next = p_chan;   green_next = q_chan;   blue_next = s2_v_reg;
            end
            hsv2rgb_pkg::SECTOR_4:
            begin
                red_next = t_chan;   green_next = p_chan;   blue_next = s2_v_reg;
            end
            default:
            begin
                red_next = s2_v_reg; green_next = p_chan;   blue_next = q_chan;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgba.valid     = out_valid_reg;
    assign rgba.red       = red_reg;
    assign rgba.green     = green_reg;
    assign rgba.blue      = blue_reg;
    assign rgba.alpha_out = alpha_level_reg;

endmodule

>>> sim/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps

module hsv_to_rgb_checker
    import hsv2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CHAN_W-1:0] cfg_wdata,
    hsv_pixel_if              hsv,
    rgba_pixel_if             rgba,
    output int unsigned       mismatches,
    output int unsigned       checked,
    output int unsigned       pending
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_pixel_t;

    rgba_pixel_t       rgba_expected_q[$];
    logic [CHAN_W-1:0] alpha_copy = ALPHA_RESET;
    int unsigned       mismatch_count = 0;
    int unsigned       checked_count = 0;
    int unsigned       pending_count = 0;

    assign mismatches = mismatch_count;
    assign checked    = checked_count;
    assign pending    = pending_count;

    // floor(v * num / den); every product stays below 2^32
    function automatic logic [CHAN_W-1:0] scale_channel(input int unsigned v,
                                                        input int unsigned num,
                                                        input int unsigned den);
        int unsigned prod;
        prod = (v * num) / den;
        return prod[CHAN_W-1:0];
    endfunction

    function automatic rgba_pixel_t hsv_to_rgba(input logic [HUE_W-1:0]  hue,
                                                input logic [CHAN_W-1:0] sat,
                                                input logic [CHAN_W-1:0] val,
                                                input logic [CHAN_W-1:0] alpha);
        int unsigned       one_q;
        int unsigned       frac;
        int unsigned       full_scale;
        int unsigned       turn;
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] q;
        logic [CHAN_W-1:0] t;
        sector_t           sec;
        rgba_pixel_t       px;
        one_q      = 1 << FRAC_BITS;
        frac       = int'(hue) & (one_q - 1);
        full_scale = 255 * one_q;
        // sectors 6 and 7 wrap back to 0 and 1
        turn       = (int'(hue) >> FRAC_BITS) % 6;
        sec        = sector_t'(turn[2:0]);
        p = scale_channel(val, 255 - int'(sat), 255);
        q = scale_channel(val, full_scale - int'(sat) * frac, full_scale);
        t = scale_channel(val, full_scale - int'(sat) * (one_q - frac), full_scale);
        case (sec)
            SECTOR_0: px = '{val, t, p, alpha};
            SECTOR_1: px = '{q, val, p, alpha};
            SECTOR_2: px = '{p, val, t, alpha};
            SECTOR_3: px = '{p, q, val, alpha};
            SECTOR_4: px = '{t, p, val, alpha};
            default:  px = '{val, p, q, alpha};
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("[%0t] MISMATCH pixel %0d %s: got %0d, expected %0d",
                 $time, checked_count, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgba_pixel_t want;
        if (!rst_n)
        begin
            alpha_copy <= ALPHA_RESET;
            rgba_expected_q.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                alpha_copy <= cfg_wdata;
            end
            if (hsv.valid && hsv.ready)
            begin
                rgba_expected_q.push_back(hsv_to_rgba(hsv.hue_fixed, hsv.saturation,
                                                      hsv.brightness, alpha_copy));
            end
            if (rgba.valid && rgba.ready)
            begin
                if (rgba_expected_q.size() == 0)
                begin
                    report_mismatch("result with no pixel outstanding, red", rgba.red, 0);
                end
                else
                begin
                    want = rgba_expected_q.pop_front();
                    if (rgba.red !== want.red)
                        report_mismatch("red", rgba.red, want.red);
                    if (rgba.green !== want.green)
                        report_mismatch("green", rgba.green, want.green);
                    if (rgba.blue !== want.blue)
                        report_mismatch("blue", rgba.blue, want.blue);
                    if (rgba.alpha_out !== want.alpha)
                        report_mismatch("alpha_out", rgba.alpha_out, want.alpha);
                    checked_count++;
                end
            end
            pending_count <= rgba_expected_q.size();
        end
    end

endmodule

>>> sim/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int LATENCY       = 3;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_PIXELS  = 286;
    localparam int DIRECTED      = 20;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CHAN_W-1:0] cfg_wdata;

    int unsigned mismatches;
    int unsigned checked;
    int unsigned pending;
    int unsigned sent_count = 0;
    int unsigned wrapped_count = 0;
    int unsigned alpha_settings = 1;
    int unsigned stall_cycles = 0;
    int          send_mode = 0;
    int          recv_mode = 0;

    logic [HUE_W-1:0] dir_hue [DIRECTED] = '{
        0, 255, 256, 512, 768, 1024, 1280, 1535, 1536, 1792,
        2047, 128, 900, 1100, 640, 1400, 2000, 384, 1300, 1600};
    logic [CHAN_W-1:0] dir_sat [DIRECTED] = '{
        255, 255, 255, 255, 255, 255, 255, 255, 255, 200,
        255, 0, 255, 0, 128, 1, 254, 255, 77, 255};
    logic [CHAN_W-1:0] dir_val [DIRECTED] = '{
        255, 255, 255, 255, 255, 255, 255, 255, 255, 180,
        255, 200, 0, 0, 255, 254, 1, 128, 201, 255};

    hsv_pixel_if  hsv_ch ();
    rgba_pixel_if rgba_ch ();

    hsv_to_rgb_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .hsv       (hsv_ch),
        .rgba      (rgba_ch)
    );

    hsv_to_rgb_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .hsv        (hsv_ch),
        .rgba       (rgba_ch),
        .mismatches (mismatches),
        .checked    (checked),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mode 0: full random gaps, mode 1: back to back, mode 2: occasional gaps
    function automatic int draw_wait(input int mode);
        int cycles;
        case (mode)
            0:       cycles = $urandom_range(0, 13);
            1:       cycles = 0;
            default: cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
        return cycles;
    endfunction

    function automatic logic [HUE_W-1:0] draw_hue();
        logic [HUE_W-1:0] h;
        case ($urandom_range(0, 9))
            0:
            begin
                // land on a sector boundary or its last fraction step
                h[HUE_W-1:FRAC_BITS] = SECTOR_W'($urandom_range(0, 7));
                h[FRAC_BITS-1:0]     = $urandom_range(0, 1) ? '1
                                                            : FRAC_BITS'($urandom_range(0, 1));
            end
            1:       h = HUE_W'($urandom_range(1537, 2047));
            default: h = HUE_W'($urandom_range(0, 1536));
        endcase
        return h;
    endfunction

    function automatic logic [CHAN_W-1:0] draw_chan();
        logic [CHAN_W-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = $urandom_range(0, 1) ? FULL : '0;
            default: c = CHAN_W'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic send_pixel(input logic [HUE_W-1:0]  hue,
                              input logic [CHAN_W-1:0] sat,
                              input logic [CHAN_W-1:0] val);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            hsv_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue_fixed  <= hue;
        hsv_ch.saturation <= sat;
        hsv_ch.brightness <= val;
        @(posedge clk);
        while (!hsv_ch.ready) @(posedge clk);
        sent_count++;
        if (hue[HUE_W-1:FRAC_BITS] >= SECTOR_W'(6))
        begin
            wrapped_count++;
        end
    endtask

    // hold the sender until every outstanding pixel has come out
    task automatic wait_drained();
        hsv_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_alpha(input logic [CHAN_W-1:0] level);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(posedge clk);
        cfg_we    <= 1'b0;
        alpha_settings++;
    endtask

    initial
    begin
        logic [CHAN_W-1:0] level;
        hsv_ch.valid      <= 1'b0;
        hsv_ch.hue_fixed  <= '0;
        hsv_ch.saturation <= '0;
        hsv_ch.brightness <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners and every sector at the reset alpha
        for (int i = 0; i < DIRECTED; i++)
        begin
            send_pixel(dir_hue[i], dir_sat[i], dir_val[i]);
        end
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       level = '0;
                2:       level = FULL;
                default: level = CHAN_W'($urandom_range(1, 254));
            endcase
            write_alpha(level);
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if (i % 48 == 0)
                begin
                    send_mode = $urandom_range(0, 2);
                end
                if (ph % 2 == 1 && i == PHASE_PIXELS / 2)
                begin
                    wait_drained();
                end
                send_pixel(draw_hue(), draw_chan(), draw_chan());
            end
            wait_drained();
        end

        $display("Covered %0d pixels (%0d in hue sectors 6 and 7) over %0d alpha settings",
                 sent_count, wrapped_count, alpha_settings);
        $display("Compared %0d RGBA results, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
        begin
            $display("hsv_to_rgb_converter verification clean");
        end
        else
        begin
            $display("hsv_to_rgb_converter verification failed");
        end
        $finish;
    end

    initial
    begin
        int stall;
        int taken;
        taken = 0;
        rgba_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
            begin
                recv_mode = $urandom_range(0, 2);
            end
            stall = draw_wait(recv_mode);
            if (stall > 0)
            begin
                rgba_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rgba_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rgba_ch.valid) @(posedge clk);
            taken++;
        end
    end

    // abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsv_ch.valid && hsv_ch.ready) || (rgba_ch.valid && rgba_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("hsv_to_rgb_converter verification failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule

>>> hsv_to_rgb_converter.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_if.sv
src/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_checker.sv
sim/tb_hsv_to_rgb_converter.sv
